[hw/rtl/bzs_pkg.sv]
// Shared types and constants for the quintic Bezier surface pixel shader.
// No dependencies; used by bezier_surface_pixel_shader.
package bzs_pkg;

    localparam int GRID_SIDE      = 4;
    localparam int POINT_COUNT    = GRID_SIDE * GRID_SIDE;
    localparam int INDEX_BITS_DEF = 8;
    localparam int FRAC           = 16;
    localparam int SUM_FRAC       = 40;

    // shared multiplier and accumulator widths
    localparam int MUL_A_W = 21;
    localparam int MUL_B_W = 34;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int INNER_W = 34;
    localparam int ACC_W   = 50;
    localparam int WGT_W   = 20;

    localparam int CNT_RESET   = 160;
    localparam int ROWS_RESET  = 120;
    localparam int RED_RESET   = 11;
    localparam int GREEN_RESET = 5;
    localparam int BLUE_RESET  = 0;

    typedef enum logic [2:0] {
        REG_COLUMN_COUNT = 3'd0,
        REG_ROW_COUNT    = 3'd1,
        REG_RED_SHIFT    = 3'd2,
        REG_GREEN_SHIFT  = 3'd3,
        REG_BLUE_SHIFT   = 3'd4,
        REG_OMIT_BLUE    = 3'd5
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_POW,
        ST_MAC,
        ST_DONE
    } state_t;

    // power and weight micro-ops
    typedef enum logic [3:0] {
        OP_T2 = 4'd0,
        OP_T3 = 4'd1,
        OP_T4 = 4'd2,
        OP_U2 = 4'd3,
        OP_U3 = 4'd4,
        OP_U4 = 4'd5,
        OP_W1 = 4'd6,
        OP_W2 = 4'd7,
        OP_W3 = 4'd8,
        OP_W4 = 4'd9
    } op_t;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_EVAL  = 1'b1;

endpackage

[hw/rtl/bezier_surface_pixel_shader.sv]
// Quintic Bezier surface pixel shader: 4x4 control grid, one shared multiplier.
// Depends on bzs_pkg.
// An evaluate beat runs a bit-serial division and the power/weight products for the column,
// then for the row, then the multiply-accumulates over the control grid and the output
// beat; the divider and the single multiplier are shared. A write beat stores one control
// point and gives no result.
// Reset (rst_n, async, active low) clears control points and loads register defaults.
module bezier_surface_pixel_shader #(
    parameter int INDEX_BITS = bzs_pkg::INDEX_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // config port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  func,
    input  logic [INDEX_BITS-1:0] col,
    input  logic [INDEX_BITS-1:0] row,
    input  logic [3:0]            point_index,
    input  logic signed [15:0]    point_value,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [15:0]           pixel,
    output logic [4:0]            intensity
);

    localparam int DW    = INDEX_BITS + bzs_pkg::FRAC;
    localparam int CNT_W = $clog2(DW);
    localparam logic signed [bzs_pkg::ACC_W-1:0] LEVEL3 =
        bzs_pkg::ACC_W'(3) << bzs_pkg::SUM_FRAC;
    localparam logic signed [bzs_pkg::ACC_W-1:0] LEVEL31 =
        bzs_pkg::ACC_W'(31) << bzs_pkg::SUM_FRAC;

    // config registers
    logic [8:0] column_count_reg, row_count_reg;
    logic [3:0] red_shift_reg, green_shift_reg, blue_shift_reg;
    logic       omit_blue_reg;
    logic       cfg_wr;

    bzs_pkg::state_t state_reg, state_next;
    logic signed [15:0] cp_reg [bzs_pkg::POINT_COUNT];

    logic [DW-1:0]   dvd_reg;
    logic [8:0]      rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic            axis_reg;
    logic [INDEX_BITS-1:0] row_reg;
    logic [15:0]     t_reg;
    logic [16:0]     u_reg;
    logic [15:0]     tp2_reg, tp3_reg, tp4_reg;
    logic [16:0]     up2_reg, up3_reg, up4_reg;
    logic [bzs_pkg::WGT_W-1:0] wx_reg [bzs_pkg::GRID_SIDE];
    logic [bzs_pkg::WGT_W-1:0] wy_reg [bzs_pkg::GRID_SIDE];
    bzs_pkg::op_t    op_reg;
    logic            phase_reg;
    logic [1:0]      i_reg;
    logic [2:0]      j_reg;
    logic signed [bzs_pkg::PROD_W-1:0]  prod_reg;
    logic signed [bzs_pkg::INNER_W-1:0] inner_reg;
    logic signed [bzs_pkg::ACC_W-1:0]   sum_reg;

    logic        out_valid_reg;
    logic [15:0] pixel_reg;
    logic [4:0]  intensity_reg;

    logic in_fire, eval_fire, out_load;

    // divider step
    logic [8:0]    div_c;
    logic [9:0]    rem_sh;
    logic          q_bit;
    logic [DW-1:0] dvd_new;
    logic [8:0]    rem_new;
    logic [15:0]   t_new;
    logic          div_last;

    logic signed [bzs_pkg::MUL_A_W-1:0] mul_a;
    logic signed [bzs_pkg::MUL_B_W-1:0] mul_b;
    logic [15:0] prod_hi;
    logic [bzs_pkg::WGT_W-1:0] wgt_val;
    logic [1:0] wgt_idx;

    logic [4:0]  level;
    logic [15:0] base;
    logic [20:0] pix_full;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign in_stall = (state_reg != bzs_pkg::ST_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign eval_fire = in_fire && (func == bzs_pkg::FUNC_EVAL);
    assign out_load = (state_reg == bzs_pkg::ST_DONE) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign pixel     = pixel_reg;
    assign intensity = intensity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= 9'(bzs_pkg::CNT_RESET);
            row_count_reg    <= 9'(bzs_pkg::ROWS_RESET);
            red_shift_reg    <= 4'(bzs_pkg::RED_RESET);
            green_shift_reg  <= 4'(bzs_pkg::GREEN_RESET);
            blue_shift_reg   <= 4'(bzs_pkg::BLUE_RESET);
            omit_blue_reg    <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                bzs_pkg::REG_COLUMN_COUNT: column_count_reg <= pwdata[8:0];
                bzs_pkg::REG_ROW_COUNT:    row_count_reg    <= pwdata[8:0];
                bzs_pkg::REG_RED_SHIFT:    red_shift_reg    <= pwdata[3:0];
                bzs_pkg::REG_GREEN_SHIFT:  green_shift_reg  <= pwdata[3:0];
                bzs_pkg::REG_BLUE_SHIFT:   blue_shift_reg   <= pwdata[3:0];
                bzs_pkg::REG_OMIT_BLUE:    omit_blue_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            bzs_pkg::REG_COLUMN_COUNT: prdata = 32'(column_count_reg);
            bzs_pkg::REG_ROW_COUNT:    prdata = 32'(row_count_reg);
            bzs_pkg::REG_RED_SHIFT:    prdata = 32'(red_shift_reg);
            bzs_pkg::REG_GREEN_SHIFT:  prdata = 32'(green_shift_reg);
            bzs_pkg::REG_BLUE_SHIFT:   prdata = 32'(blue_shift_reg);
            bzs_pkg::REG_OMIT_BLUE:    prdata = 32'(omit_blue_reg);
            default:                   prdata = 32'd0;
        endcase
    end

    // restoring divider, one quotient bit per cycle; a zero count acts as one
    always_comb
    begin
        div_c    = axis_reg ? row_count_reg : column_count_reg;
        if (div_c == 9'd0)
        begin
            div_c = 9'd1;
        end
        rem_sh   = {rem_reg, dvd_reg[DW-1]};
        q_bit    = (rem_sh >= {1'b0, div_c});
        rem_new  = q_bit ? 9'(rem_sh - {1'b0, div_c}) : rem_sh[8:0];
        dvd_new  = {dvd_reg[DW-2:0], q_bit};
        t_new    = (|dvd_new[DW-1:bzs_pkg::FRAC]) ? 16'hFFFF : dvd_new[15:0];
        div_last = (cnt_reg == CNT_W'(DW - 1));
    end

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == bzs_pkg::ST_POW)
        begin
            case (op_reg)
                bzs_pkg::OP_T2: begin mul_a = 21'(t_reg);   mul_b = 34'(t_reg);   end
                bzs_pkg::OP_T3: begin mul_a = 21'(tp2_reg); mul_b = 34'(t_reg);   end
                bzs_pkg::OP_T4: begin mul_a = 21'(tp3_reg); mul_b = 34'(t_reg);   end
                bzs_pkg::OP_U2: begin mul_a = 21'(u_reg);   mul_b = 34'(u_reg);   end
                bzs_pkg::OP_U3: begin mul_a = 21'(up2_reg); mul_b = 34'(u_reg);   end
                bzs_pkg::OP_U4: begin mul_a = 21'(up3_reg); mul_b = 34'(u_reg);   end
                bzs_pkg::OP_W1: begin mul_a = 21'(t_reg);   mul_b = 34'(up4_reg); end
                bzs_pkg::OP_W2: begin mul_a = 21'(tp2_reg); mul_b = 34'(up3_reg); end
                bzs_pkg::OP_W3: begin mul_a = 21'(tp3_reg); mul_b = 34'(up2_reg); end
                bzs_pkg::OP_W4: begin mul_a = 21'(tp4_reg); mul_b = 34'(u_reg);   end
                default: ;
            endcase
        end
        else if (state_reg == bzs_pkg::ST_MAC)
        begin
            if (j_reg == 3'd4)
            begin
                mul_a = 21'(wx_reg[i_reg]);
                mul_b = inner_reg;
            end
            else
            begin
                mul_a = 21'(wy_reg[j_reg[1:0]]);
                mul_b = 34'(cp_reg[{i_reg, j_reg[1:0]}]);
            end
        end
    end

    // binomial factor: 5 for the outer weights, 10 for the middle ones
    always_comb
    begin
        prod_hi = prod_reg[31:16];
        wgt_idx = 2'(op_reg - bzs_pkg::OP_W1);
        if (wgt_idx == 2'd0 || wgt_idx == 2'd3)
        begin
            wgt_val = (20'(prod_hi) << 2) + 20'(prod_hi);
        end
        else
        begin
            wgt_val = (20'(prod_hi) << 3) + (20'(prod_hi) << 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bzs_pkg::ST_IDLE;
            for (int k = 0; k < bzs_pkg::POINT_COUNT; k++)
            begin
                cp_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire && func == bzs_pkg::FUNC_WRITE)
            begin
                cp_reg[point_index] <= point_value;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bzs_pkg::ST_IDLE: if (eval_fire) state_next = bzs_pkg::ST_DIV;
            bzs_pkg::ST_DIV:  if (div_last) state_next = bzs_pkg::ST_POW;
            bzs_pkg::ST_POW:
                if (phase_reg && op_reg == bzs_pkg::OP_W4)
                begin
                    state_next = axis_reg ? bzs_pkg::ST_MAC : bzs_pkg::ST_DIV;
                end
            bzs_pkg::ST_MAC:
                if (phase_reg && j_reg == 3'd4 && i_reg == 2'd3)
                begin
                    state_next = bzs_pkg::ST_DONE;
                end
            bzs_pkg::ST_DONE: if (out_load) state_next = bzs_pkg::ST_IDLE;
            default: state_next = bzs_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            bzs_pkg::ST_IDLE:
            begin
                dvd_reg   <= {col, 16'd0};
                rem_reg   <= '0;
                cnt_reg   <= '0;
                axis_reg  <= 1'b0;
                row_reg   <= row;
                inner_reg <= '0;
                sum_reg   <= '0;
                phase_reg <= 1'b0;
                op_reg    <= bzs_pkg::OP_T2;
                i_reg     <= '0;
                j_reg     <= '0;
            end
            bzs_pkg::ST_DIV:
            begin
                dvd_reg <= dvd_new;
                rem_reg <= rem_new;
                cnt_reg <= cnt_reg + 1'b1;
                if (div_last)
                begin
                    t_reg     <= t_new;
                    u_reg     <= 17'h10000 - 17'(t_new);
                    phase_reg <= 1'b0;
                    op_reg    <= bzs_pkg::OP_T2;
                end
            end
            bzs_pkg::ST_POW:
            begin
                phase_reg <= !phase_reg;
                if (!phase_reg)
                begin
                    prod_reg <= mul_a * mul_b;
                end
                else
                begin
                    case (op_reg)
                        bzs_pkg::OP_T2: tp2_reg <= prod_reg[31:16];
                        bzs_pkg::OP_T3: tp3_reg <= prod_reg[31:16];
                        bzs_pkg::OP_T4: tp4_reg <= prod_reg[31:16];
                        bzs_pkg::OP_U2: up2_reg <= prod_reg[32:16];
                        bzs_pkg::OP_U3: up3_reg <= prod_reg[32:16];
                        bzs_pkg::OP_U4: up4_reg <= prod_reg[32:16];
                        default:
                            if (axis_reg)
                            begin
                                wy_reg[wgt_idx] <= wgt_val;
                            end
                            else
                            begin
                                wx_reg[wgt_idx] <= wgt_val;
                            end
                    endcase
                    op_reg <= bzs_pkg::op_t'(op_reg + 4'd1);
                    if (op_reg == bzs_pkg::OP_W4)
                    begin
                        // weights done: set up the row division, which runs only after the x weights
                        dvd_reg  <= {row_reg, 16'd0};
                        rem_reg  <= '0;
                        cnt_reg  <= '0;
                        axis_reg <= 1'b1;
                    end
                end
            end
            bzs_pkg::ST_MAC:
            begin
                phase_reg <= !phase_reg;
                if (!phase_reg)
                begin
                    prod_reg <= mul_a * mul_b;
                end
                else if (j_reg == 3'd4)
                begin
                    sum_reg   <= sum_reg + $signed(prod_reg[bzs_pkg::ACC_W-1:0]);
                    inner_reg <= '0;
                    j_reg     <= '0;
                    i_reg     <= i_reg + 1'b1;
                end
                else
                begin
                    inner_reg <= inner_reg + $signed(prod_reg[bzs_pkg::INNER_W-1:0]);
                    j_reg     <= j_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // clamp, mask with 30, scale by the color base
    always_comb
    begin
        if (sum_reg <= 0)
        begin
            level = 5'd0;
        end
        else if (sum_reg < LEVEL3)
        begin
            level = 5'd3;
        end
        else if (sum_reg > LEVEL31)
        begin
            level = 5'd31;
        end
        else
        begin
            level = sum_reg[bzs_pkg::SUM_FRAC+4:bzs_pkg::SUM_FRAC];
        end
        level = level & 5'd30;
        base  = (16'd1 << red_shift_reg) + (16'd1 << green_shift_reg)
              + (omit_blue_reg ? 16'd0 : (16'd1 << blue_shift_reg));
        pix_full = 21'(base) * 21'(level);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pixel_reg     <= pix_full[15:0];
            intensity_reg <= level;
        end
    end

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == bzs_pkg::ST_DONE))
        else $error("result beat raised outside the done state");

    a_even_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (intensity[0] == 1'b0))
        else $error("intensity has its low bit set");

    a_mac_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bzs_pkg::ST_MAC) |-> (j_reg <= 3'd4))
        else $error("accumulate step index out of range");

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        eval_fire |=> in_stall)
        else $error("evaluate beat did not block the input");

endmodule
